/* src/b64d_pkg.sv */
`default_nettype none
package b64d_pkg;

   localparam logic [7:0] PAD_CHAR   = 8'h3D;
   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] TAB_CHAR   = 8'h09;
   localparam logic [7:0] CR_CHAR    = 8'h0D;

   localparam logic [1:0] PHASE_0 = 2'd0;
   localparam logic [1:0] PHASE_1 = 2'd1;
   localparam logic [1:0] PHASE_2 = 2'd2;
   localparam logic [1:0] PHASE_3 = 2'd3;

   typedef struct packed {
      logic [1:0]  group_phase;
      logic [5:0]  held_sextet;
      logic        pad_pending;
      logic        pad_done;
      logic        data_started;
      logic [15:0] space_run;
      logic [15:0] trimmed_length;
      logic [15:0] bytes_out;
      logic        error_seen;
   } dec_state_type;

   typedef struct packed {
      logic        produce;
      logic        byte_valid;
      logic [7:0]  data_byte;
      logic        final_res;
      logic        error;
      logic [15:0] byte_count;
   } dec_result_type;

   localparam dec_state_type STATE_RESET = '{
      group_phase:    PHASE_0,
      held_sextet:    6'd0,
      pad_pending:    1'b0,
      pad_done:       1'b0,
      data_started:   1'b0,
      space_run:      16'd0,
      trimmed_length: 16'd0,
      bytes_out:      16'd0,
      error_seen:     1'b0
   };

   // space, tab, LF, VT, FF, CR
   function automatic logic is_blank(input logic [7:0] c);
      return (c == SPACE_CHAR) || ((c >= TAB_CHAR) && (c <= CR_CHAR));
   endfunction

   // bit 6: character is in the alphabet, bits 5:0: its value
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [6:0] r;
      r = 7'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = {1'b1, 6'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r = {1'b1, 6'(c - 8'h47)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 6'(c + 8'h04)};
      end else if (c == 8'h2B) begin
         r = {1'b1, 6'd62};
      end else if (c == 8'h2F) begin
         r = {1'b1, 6'd63};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* src/b64d_step.sv */
`default_nettype none
module b64d_step
   import b64d_pkg::*;
#(
   parameter int MAX_TEXT_LEN = 65535
) (
   input  wire logic [7:0]     char_in,
   input  wire logic           last_in,
   input  wire logic [15:0]    capacity,
   input  wire dec_state_type  cur,
   output dec_state_type       nxt,
   output dec_result_type      res
);

   localparam logic [16:0] MAX_LEN = 17'(MAX_TEXT_LEN);

   logic [6:0]  sx;
   logic [5:0]  s;
   logic        s_ok;
   logic        is_pad;
   logic [16:0] len_sum;
   logic        hb;
   logic [7:0]  b;
   logic [13:0] quads;
   logic [16:0] need;
   logic        bad;
   dec_state_type upd;

   assign sx     = sextet_of(char_in);
   assign s_ok   = sx[6];
   assign s      = sx[5:0];
   assign is_pad = (char_in == PAD_CHAR);

   assign len_sum = {1'b0, cur.trimmed_length} + {1'b0, cur.space_run} + 17'd1;

   always_comb begin
      upd = cur;
      hb  = 1'b0;
      b   = 8'd0;
      if (is_blank(char_in)) begin
         if (cur.data_started && ({1'b0, cur.space_run} < MAX_LEN)) begin
            upd.space_run = cur.space_run + 16'd1;
         end
      end else begin
         if (cur.data_started && (cur.space_run != 16'd0) && !cur.pad_done) begin
            upd.error_seen = 1'b1;
         end
         upd.data_started = 1'b1;
         if (len_sum > MAX_LEN) begin
            upd.trimmed_length = MAX_LEN[15:0];
            upd.error_seen     = 1'b1;
         end else begin
            upd.trimmed_length = len_sum[15:0];
         end
         upd.space_run = 16'd0;
         if (!cur.pad_done && !upd.error_seen) begin
            if (cur.pad_pending) begin
               upd.pad_pending = 1'b0;
               if (is_pad) upd.pad_done = 1'b1;
               else upd.error_seen = 1'b1;
            end else begin
               case (cur.group_phase)
                  PHASE_0: begin
                     if (!s_ok) begin
                        upd.error_seen = 1'b1;
                     end else begin
                        upd.held_sextet = s;
                        upd.group_phase = PHASE_1;
                     end
                  end
                  PHASE_1: begin
                     if (!s_ok) begin
                        upd.error_seen = 1'b1;
                     end else begin
                        b               = {cur.held_sextet, s[5:4]};
                        hb              = 1'b1;
                        upd.held_sextet = s;
                        upd.group_phase = PHASE_2;
                     end
                  end
                  PHASE_2: begin
                     if (is_pad) begin
                        upd.pad_pending = 1'b1;
                     end else if (!s_ok) begin
                        upd.error_seen = 1'b1;
                     end else begin
                        b               = {cur.held_sextet[3:0], s[5:2]};
                        hb              = 1'b1;
                        upd.held_sextet = s;
                        upd.group_phase = PHASE_3;
                     end
                  end
                  default: begin
                     if (is_pad) begin
                        upd.pad_done = 1'b1;
                     end else if (!s_ok) begin
                        upd.error_seen = 1'b1;
                     end else begin
                        b               = {cur.held_sextet[1:0], s};
                        hb              = 1'b1;
                        upd.group_phase = PHASE_0;
                     end
                  end
               endcase
            end
            if (hb) upd.bytes_out = cur.bytes_out + 16'd1;
         end
      end
   end

   // length/4*3+1 against the destination size
   assign quads = upd.trimmed_length[15:2];
   assign need  = {2'b00, quads, 1'b0} + {3'b000, quads} + 17'd1;
   assign bad   = upd.error_seen || upd.pad_pending || (upd.trimmed_length[1:0] != 2'd0) ||
                  (need > {1'b0, capacity});

   always_comb begin
      nxt            = last_in ? STATE_RESET : upd;
      res.produce    = hb || last_in;
      res.byte_valid = hb;
      res.data_byte  = b;
      res.final_res  = last_in;
      res.error      = last_in && bad;
      res.byte_count = upd.bytes_out;
   end

endmodule
`default_nettype wire

/* src/base64_stream_decoder.sv */
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_in_char, req_last_char
// rsp       out        rsp_valid/rsp_stall   rsp_byte_valid, rsp_data_byte, rsp_final_res,
//                                            rsp_error, rsp_byte_count
// csr       in         csr_wr_en             csr_wr_data (out_capacity)
//
// One character per cycle while the response side does not stall; a request passes the
// input register, then is decoded into the response register.
// Characters that produce no response retire without touching the response register.
// A stalled response holds the decode stage only when the next character needs a slot.
// Synchronous reset clears all control state and sets out_capacity to 65535.
`default_nettype none
module base64_stream_decoder
   import b64d_pkg::*;
#(
   parameter int MAX_TEXT_LEN = 65535
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_in_char,
   input  wire logic        req_last_char,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_byte_valid,
   output      logic [7:0]  rsp_data_byte,
   output      logic        rsp_final_res,
   output      logic        rsp_error,
   output      logic [15:0] rsp_byte_count,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   logic           in_valid_ff;
   logic           in_valid_in;
   logic [7:0]     in_char_ff;
   logic           in_last_ff;
   logic           in_load;
   logic [15:0]    capacity_ff;
   dec_state_type  state_ff;
   dec_state_type  state_in;
   dec_result_type res;
   logic           out_free;
   logic           fire;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   dec_result_type rsp_ff;

   b64d_step #(
      .MAX_TEXT_LEN(MAX_TEXT_LEN)
   ) u_step (
      .char_in  (in_char_ff),
      .last_in  (in_last_ff),
      .capacity (capacity_ff),
      .cur      (state_ff),
      .nxt      (state_in),
      .res      (res)
   );

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   // retire the held request unless it needs the response slot and the slot is full and stalled
   assign fire        = in_valid_ff && (!res.produce || out_free);
   assign in_load     = !in_valid_ff || fire;
   assign req_stall   = !in_load;
   assign in_valid_in = in_load ? req_valid : in_valid_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (fire && res.produce) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
         capacity_ff  <= 16'hFFFF;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) state_ff <= state_in;
         if (csr_wr_en) capacity_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         in_char_ff <= req_in_char;
         in_last_ff <= req_last_char;
      end
      if (fire && res.produce) rsp_ff <= res;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_byte_valid = rsp_ff.byte_valid;
   assign rsp_data_byte  = rsp_ff.data_byte;
   assign rsp_final_res  = rsp_ff.final_res;
   assign rsp_error      = rsp_ff.error;
   assign rsp_byte_count = rsp_ff.byte_count;

   a_err_only_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_ff.error || rsp_ff.final_res))
      else $error("error flag on a non-final response");

   a_idle_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.byte_valid |-> (rsp_ff.data_byte == 8'd0))
      else $error("data byte set without byte_valid");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      fire && in_last_ff |=> (!state_ff.data_started && (state_ff.trimmed_length == 16'd0)
                              && (state_ff.bytes_out == 16'd0)))
      else $error("state not cleared after final character");

   a_pad_exclusive: assert property (@(posedge clock) disable iff (reset)
      state_ff.pad_done |-> !state_ff.pad_pending)
      else $error("pad pending after padding finished");

   a_no_silent_drop: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && res.produce && rsp_valid_ff && rsp_stall |=> in_valid_ff)
      else $error("request retired while response slot was full");

endmodule
`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps
module tb;
   import b64d_pkg::*;

   localparam int MAX_TEXT    = 65535;
   localparam int LATENCY     = 2;
   localparam int QUIET_LIMIT = 2000;

   typedef struct {
      logic        byte_valid;
      logic [7:0]  data_byte;
      logic        final_res;
      logic        error;
      logic [15:0] byte_count;
   } decoded_t;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_char   = 8'h00;
   logic        req_last_char = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic        rsp_byte_valid;
   logic [7:0]  rsp_data_byte;
   logic        rsp_final_res;
   logic        rsp_error;
   logic [15:0] rsp_byte_count;
   logic        csr_wr_en     = 1'b0;
   logic [15:0] csr_wr_data   = 16'h0000;

   base64_stream_decoder #(.MAX_TEXT_LEN(MAX_TEXT)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_char    (req_in_char),
      .req_last_char  (req_last_char),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_final_res  (rsp_final_res),
      .rsp_error      (rsp_error),
      .rsp_byte_count (rsp_byte_count),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #2 clock = ~clock;

   // decoder state as seen from outside
   logic [15:0] capacity_reg = 16'hFFFF;
   logic [1:0]  grp_phase    = PHASE_0;
   logic [5:0]  held         = 6'd0;
   logic        pad_pending  = 1'b0;
   logic        pad_done     = 1'b0;
   logic        started      = 1'b0;
   logic        text_bad     = 1'b0;
   int          space_run    = 0;
   int          trim_len     = 0;
   logic [15:0] bytes_out    = 16'd0;

   decoded_t    decoded_q[$];
   logic [7:0]  text_buf[$];
   int          mismatch_count = 0;
   int          sent_items     = 0;
   int          send_idle_pct  = 0;
   int          rsp_idle_pct   = 0;
   int          hold_request   = 0;

   function automatic logic whitespace(input logic [7:0] c);
      return c == SPACE_CHAR || (c >= TAB_CHAR && c <= CR_CHAR);
   endfunction

   function automatic int sextet_value(input logic [7:0] c);
      if (c >= "A" && c <= "Z") return int'(c) - 65;
      if (c >= "a" && c <= "z") return int'(c) - 97 + 26;
      if (c >= "0" && c <= "9") return int'(c) - 48 + 52;
      if (c == "+") return 62;
      if (c == "/") return 63;
      return -1;
   endfunction

   function automatic logic [7:0] rand_alpha();
      int v;
      v = $urandom_range(63);
      if (v < 26) return 8'(65 + v);
      if (v < 52) return 8'(97 + v - 26);
      if (v < 62) return 8'(48 + v - 52);
      return (v == 62) ? 8'h2B : 8'h2F;
   endfunction

   function automatic logic [7:0] rand_blank();
      int k;
      k = $urandom_range(5);
      return (k == 5) ? SPACE_CHAR : 8'(TAB_CHAR + k);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
      end
   endtask

   // advance the decoder by one accepted character and queue what it yields
   task automatic decode_step(input logic [7:0] c, input logic last);
      decoded_t   r;
      int         sx;
      logic       got_byte;
      logic [7:0] b;
      got_byte = 1'b0;
      b = 8'h00;
      if (whitespace(c)) begin
         if (started && space_run < MAX_TEXT) space_run++;
      end else begin
         if (started && space_run > 0 && !pad_done) text_bad = 1'b1;
         started = 1'b1;
         if (trim_len + space_run + 1 > MAX_TEXT) begin
            trim_len = MAX_TEXT;
            text_bad = 1'b1;
         end else begin
            trim_len = trim_len + space_run + 1;
         end
         space_run = 0;
         if (!pad_done && !text_bad) begin
            sx = sextet_value(c);
            if (pad_pending) begin
               pad_pending = 1'b0;
               if (c == PAD_CHAR) pad_done = 1'b1;
               else text_bad = 1'b1;
            end else if (c == PAD_CHAR && grp_phase == PHASE_2) begin
               pad_pending = 1'b1;
            end else if (c == PAD_CHAR && grp_phase == PHASE_3) begin
               pad_done = 1'b1;
            end else if (sx < 0) begin
               text_bad = 1'b1;
            end else begin
               case (grp_phase)
                  PHASE_1: b = {held, sx[5:4]};
                  PHASE_2: b = {held[3:0], sx[5:2]};
                  PHASE_3: b = {held[1:0], sx[5:0]};
                  default: b = 8'h00;
               endcase
               got_byte = (grp_phase != PHASE_0);
               held = 6'(sx);
               grp_phase = grp_phase + 2'd1;
               if (got_byte) bytes_out = bytes_out + 16'd1;
            end
         end
      end
      if (got_byte || last) begin
         r.byte_valid = got_byte;
         r.data_byte  = b;
         r.final_res  = last;
         r.error      = 1'b0;
         r.byte_count = bytes_out;
         if (last) begin
            r.error = text_bad || pad_pending || (trim_len % 4 != 0) ||
                      (trim_len / 4 * 3 + 1 > int'(capacity_reg));
            grp_phase   = PHASE_0;
            held        = 6'd0;
            pad_pending = 1'b0;
            pad_done    = 1'b0;
            started     = 1'b0;
            text_bad    = 1'b0;
            space_run   = 0;
            trim_len    = 0;
            bytes_out   = 16'd0;
         end
         decoded_q.push_back(r);
      end
   endtask

   task automatic send_char(input logic [7:0] c, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_in_char   <= c;
      req_last_char <= last;
      do @(posedge clock); while (req_stall);
      sent_items++;
      decode_step(c, last);
   endtask

   task automatic send_text();
      foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1);
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   // drop the request and let every outstanding response come back
   task automatic drain();
      req_valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [15:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      capacity_reg = value;
   endtask

   task automatic build_wellformed();
      int groups;
      int pads;
      text_buf.delete();
      repeat ($urandom_range(2)) text_buf.push_back(rand_blank());
      groups = $urandom_range(1, 5);
      pads = $urandom_range(2);
      for (int g = 0; g < groups; g++) begin
         for (int k = 0; k < 4; k++) begin
            text_buf.push_back((g == groups - 1 && k >= 4 - pads) ? PAD_CHAR : rand_alpha());
         end
      end
      // characters after the padding are skipped but still counted
      if (pads != 0 && $urandom_range(7) == 0) begin
         repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(255)));
      end
      repeat ($urandom_range(2)) text_buf.push_back(rand_blank());
   endtask

   task automatic test_directed();
      send_string(" /+9z\t");
      send_string("AA== z");
      send_string("AB=C");
      send_string("AB=");
      send_string("A B");
      send_string(" ");
      send_char(8'hFF, 1'b0);
      send_char(8'h80, 1'b1);
   endtask

   task automatic test_capacity();
      logic [15:0] caps [4] = '{16'd1, 16'd4, 16'd7, 16'hFFFF};
      for (int i = 0; i < 4; i++) begin
         set_capacity(caps[i]);
         send_string("AAAA");
         send_string("AAAAAAAA");
         send_string(" ");
      end
   endtask

   task automatic test_random(input int send_pct, input int rsp_pct, input int quota);
      int first;
      int texts;
      int roll;
      int idx;
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
      first = sent_items;
      texts = 0;
      while (sent_items - first < quota) begin
         if (texts % 16 == 0) begin
            case ($urandom_range(3))
               0:       set_capacity(16'hFFFF);
               1:       set_capacity(16'd1);
               default: set_capacity(16'($urandom_range(2, 24)));
            endcase
         end
         roll = $urandom_range(99);
         if (roll < 90) begin
            build_wellformed();
            if (roll >= 75) begin
               idx = $urandom_range(text_buf.size() - 1);
               case ($urandom_range(3))
                  0:       text_buf[idx] = 8'($urandom_range(255));
                  1:       text_buf.insert(idx, rand_blank());
                  2:       text_buf.insert(idx, PAD_CHAR);
                  default: text_buf.delete(idx);
               endcase
               if (text_buf.size() == 0) text_buf.push_back(PAD_CHAR);
            end
         end else begin
            text_buf.delete();
            repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom_range(255)));
         end
         send_text();
         texts++;
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      drain();
      hold_request = 300;
      repeat (4) begin
         build_wellformed();
         send_text();
      end
      drain();
   endtask

   always @(posedge clock) begin : rsp_side
      decoded_t want;
      int       hold_left;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_q.size() == 0) begin
            report_mismatch($sformatf("response with nothing expected: byte %02h final %0b",
                                      rsp_data_byte, rsp_final_res));
         end else begin
            want = decoded_q.pop_front();
            check_field("byte_valid", 16'(rsp_byte_valid), 16'(want.byte_valid));
            check_field("data_byte", 16'(rsp_data_byte), 16'(want.data_byte));
            check_field("final_res", 16'(rsp_final_res), 16'(want.final_res));
            check_field("error", 16'(rsp_error), 16'(want.error));
            check_field("byte_count", rsp_byte_count, want.byte_count);
         end
      end
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("base64_stream_decoder test failed");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 32;
      rsp_idle_pct  = 74;
      test_directed();
      test_capacity();
      test_random(32, 74, 405);
      test_random(74, 32, 405);
      test_random(0, 0, 405);
      test_backpressure();
      drain();
      repeat (4 * LATENCY) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("base64_stream_decoder test passed");
      end else begin
         $display("base64_stream_decoder test failed");
      end
      $finish;
   end

endmodule

/* base64_stream_decoder.f */
src/b64d_pkg.sv
src/b64d_step.sv
src/base64_stream_decoder.sv
test/tb.sv
